### rtl/pkst_pkg.sv
// pkst_pkg: shared types, field widths and codes for the pressed key set tracker
// used by the channel interfaces and the top level; no dependencies
package pkst_pkg;

	// default number of slots in each set
	localparam int KEY_SLOTS_DEF = 16;

	localparam int KEYSYM_W   = 29;
	localparam int SCANCODE_W = 16;

	// command codes
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// key action codes
	localparam logic [1:0] ACT_DOWN   = 2'd0;
	localparam logic [1:0] ACT_UP     = 2'd1;
	localparam logic [1:0] ACT_REPEAT = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// shift keysyms and letter ranges
	localparam logic [KEYSYM_W-1:0] SHIFT_L_SYM = 29'h000FFE1;
	localparam logic [KEYSYM_W-1:0] SHIFT_R_SYM = 29'h000FFE2;
	localparam logic [KEYSYM_W-1:0] UPPER_LO    = 29'h0000041;
	localparam logic [KEYSYM_W-1:0] UPPER_HI    = 29'h000005A;
	localparam logic [KEYSYM_W-1:0] LOWER_LO    = 29'h0000061;
	localparam logic [KEYSYM_W-1:0] LOWER_HI    = 29'h000007A;
	localparam logic [KEYSYM_W-1:0] CASE_BIT    = 29'h0000020;

	typedef struct packed {
		logic                  cmd;
		logic [1:0]            key_action;
		logic [KEYSYM_W-1:0]   event_keysym;
		logic [SCANCODE_W-1:0] event_scancode;
		logic [KEYSYM_W-1:0]   query_keysym;
		logic                  query_case_insensitive;
		logic [SCANCODE_W-1:0] query_scancode;
	} item_t;

	typedef struct packed {
		logic event_processed;
		logic keysym_held;
		logic scancode_held;
		logic overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RECASE,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

### rtl/pkst_if.sv
// pkst_item_if, pkst_result_if: valid/ready channels for input items and results
// depends on pkst_pkg for the payload structs
interface pkst_item_if;
	logic            valid;
	logic            ready;
	pkst_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pkst_result_if;
	logic              valid;
	logic              ready;
	pkst_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/pressed_key_set_tracker.sv
// pressed_key_set_tracker: top level, sequencer around the keysym and scancode slot rams
// depends on pkst_pkg, pkst_if (pkst_item_if, pkst_result_if) and pkst_ram

// Keeps the set of held keysyms and the set of held scancodes, KEY_SLOTS slots
// each, in two rams with a valid flop per slot. One item is worked on at a time:
// a sweep reads every slot once (one slot per cycle, through a registered read)
// to match the key, find the lowest free slot and note which letters are held;
// a shift down or up adds a second sweep that rewrites letter case in place;
// the update state then inserts or removes. A repeat or non-key action skips the
// sweeps and goes straight to the result.
// A new item is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register. No clearing pass is needed after
// reset: the valid flops clear at once.
module pressed_key_set_tracker #(
	parameter int KEY_SLOTS = pkst_pkg::KEY_SLOTS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pkst_item_if.sink     item,
	pkst_result_if.source result
);

	localparam int IDX_W = $clog2(KEY_SLOTS);
	localparam int CNT_W = $clog2(KEY_SLOTS + 1);
	localparam int KW    = pkst_pkg::KEYSYM_W;
	localparam int SW    = pkst_pkg::SCANCODE_W;

	pkst_pkg::state_t  state_q, state_d;
	pkst_pkg::item_t   itm_q;
	pkst_pkg::result_t rsp_q, rsp_d;
	logic              rsp_vld_q;
	logic              rsp_load;

	logic [CNT_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             issue;
	logic             sweep_last;

	logic [KEY_SLOTS-1:0] ks_vld_q;
	logic [KEY_SLOTS-1:0] sc_vld_q;
	logic [KW-1:0]        ks_rd;
	logic [SW-1:0]        sc_rd;

	logic             ks_hit_q, ks_alt_q, ks_free_fnd_q;
	logic [IDX_W-1:0] ks_hit_idx_q, ks_free_idx_q;
	logic             sc_hit_q, sc_free_fnd_q;
	logic [IDX_W-1:0] sc_hit_idx_q, sc_free_idx_q;
	logic [31:0]      tgt_map_q;

	logic          accept;
	logic          is_query, is_down, is_up, is_shift, do_recase;
	logic          in_is_keyed;
	logic [KW-1:0] ks_key;
	logic [SW-1:0] sc_key;
	logic          cur_ks_v, cur_sc_v;
	logic          in_upper, in_lower, src_rng, tgt_rng, tgt_hit;
	logic          recase_clr, recase_wr;
	logic          ks_ins, sc_ins, ks_del, sc_del;
	logic          ks_we;
	logic [IDX_W-1:0] ks_waddr;
	logic [KW-1:0]    ks_wdata;
	logic          q_letter;
	logic          ovf;

	// decode of the item being worked on
	always_comb begin
		is_query  = itm_q.cmd == pkst_pkg::CMD_QUERY;
		is_down   = !is_query && itm_q.key_action == pkst_pkg::ACT_DOWN;
		is_up     = !is_query && itm_q.key_action == pkst_pkg::ACT_UP;
		is_shift  = itm_q.event_keysym == pkst_pkg::SHIFT_L_SYM ||
			itm_q.event_keysym == pkst_pkg::SHIFT_R_SYM;
		do_recase = (is_down || is_up) && is_shift;
		ks_key    = is_query ? itm_q.query_keysym : itm_q.event_keysym;
		sc_key    = is_query ? itm_q.query_scancode : itm_q.event_scancode;
		q_letter  = (itm_q.query_keysym >= pkst_pkg::UPPER_LO &&
			itm_q.query_keysym <= pkst_pkg::UPPER_HI) ||
			(itm_q.query_keysym >= pkst_pkg::LOWER_LO &&
			itm_q.query_keysym <= pkst_pkg::LOWER_HI);
		in_is_keyed = item.data.cmd == pkst_pkg::CMD_QUERY ||
			item.data.key_action == pkst_pkg::ACT_DOWN ||
			item.data.key_action == pkst_pkg::ACT_UP;
	end

	// slot returned from the rams this cycle
	always_comb begin
		cur_ks_v = ks_vld_q[rd_idx_s1];
		cur_sc_v = sc_vld_q[rd_idx_s1];
		in_upper = ks_rd >= pkst_pkg::UPPER_LO && ks_rd <= pkst_pkg::UPPER_HI;
		in_lower = ks_rd >= pkst_pkg::LOWER_LO && ks_rd <= pkst_pkg::LOWER_HI;
		// down rewrites lower to upper, up rewrites upper to lower
		src_rng  = is_down ? in_lower : in_upper;
		tgt_rng  = is_down ? in_upper : in_lower;
		tgt_hit  = tgt_map_q[ks_rd[4:0]];
		recase_clr = state_q == pkst_pkg::ST_RECASE && rd_vld_s1 && cur_ks_v &&
			src_rng && tgt_hit;
		recase_wr  = state_q == pkst_pkg::ST_RECASE && rd_vld_s1 && cur_ks_v &&
			src_rng && !tgt_hit;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pkst_pkg::ST_IDLE: begin
				if (item.valid) begin
					state_d = in_is_keyed ? pkst_pkg::ST_SCAN : pkst_pkg::ST_DONE;
				end
			end
			pkst_pkg::ST_SCAN: begin
				if (sweep_last) begin
					if (is_query) begin
						state_d = pkst_pkg::ST_DONE;
					end else if (do_recase) begin
						state_d = pkst_pkg::ST_RECASE;
					end else begin
						state_d = pkst_pkg::ST_UPDATE;
					end
				end
			end
			pkst_pkg::ST_RECASE: begin
				if (sweep_last) begin
					state_d = pkst_pkg::ST_UPDATE;
				end
			end
			pkst_pkg::ST_UPDATE: begin
				state_d = pkst_pkg::ST_DONE;
			end
			pkst_pkg::ST_DONE: begin
				if (!rsp_vld_q || result.ready) begin
					state_d = pkst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pkst_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready = state_q == pkst_pkg::ST_IDLE;
		accept     = item.valid && item.ready;
		issue      = (state_q == pkst_pkg::ST_SCAN || state_q == pkst_pkg::ST_RECASE) &&
			cnt_q != CNT_W'(KEY_SLOTS);
		sweep_last = rd_vld_s1 && cnt_q == CNT_W'(KEY_SLOTS);
		ks_ins     = state_q == pkst_pkg::ST_UPDATE && is_down && !ks_hit_q && ks_free_fnd_q;
		sc_ins     = state_q == pkst_pkg::ST_UPDATE && is_down && !sc_hit_q && sc_free_fnd_q;
		ks_del     = state_q == pkst_pkg::ST_UPDATE && is_up && ks_hit_q;
		sc_del     = state_q == pkst_pkg::ST_UPDATE && is_up && sc_hit_q;
		ks_we      = recase_wr || ks_ins;
		ks_waddr   = recase_wr ? rd_idx_s1 : ks_free_idx_q;
		ks_wdata   = recase_wr ? (ks_rd ^ pkst_pkg::CASE_BIT) : itm_q.event_keysym;
		rsp_load   = state_q == pkst_pkg::ST_DONE && (!rsp_vld_q || result.ready);
	end

	// result beat contents
	always_comb begin
		ovf   = is_down && ((!ks_hit_q && !ks_free_fnd_q) || (!sc_hit_q && !sc_free_fnd_q));
		rsp_d = '0;
		if (is_query) begin
			rsp_d.keysym_held   = ks_hit_q ||
				(itm_q.query_case_insensitive && q_letter && ks_alt_q);
			rsp_d.scancode_held = sc_hit_q;
		end else if (is_down || is_up) begin
			rsp_d.event_processed = 1'b1;
			rsp_d.overflow        = ovf;
		end
	end

	assign result.valid = rsp_vld_q;
	assign result.data  = rsp_q;

	// slot rams
	pkst_ram #(.DEPTH(KEY_SLOTS), .WIDTH(KW)) u_ks_ram (
		.clk   (clk),
		.we    (ks_we),
		.waddr (ks_waddr),
		.wdata (ks_wdata),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ks_rd)
	);

	pkst_ram #(.DEPTH(KEY_SLOTS), .WIDTH(SW)) u_sc_ram (
		.clk   (clk),
		.we    (sc_ins),
		.waddr (sc_free_idx_q),
		.wdata (itm_q.event_scancode),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (sc_rd)
	);

	// state, sweep counter and read pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pkst_pkg::ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (sweep_last) begin
				cnt_q <= '0;
			end
		end
	end

	// item capture and read slot index
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			itm_q <= item.data;
		end
	end

	// sweep accumulators: matches, lowest free slots, held case targets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_hit_q      <= 1'b0;
			ks_alt_q      <= 1'b0;
			ks_free_fnd_q <= 1'b0;
			ks_hit_idx_q  <= '0;
			ks_free_idx_q <= '0;
			sc_hit_q      <= 1'b0;
			sc_free_fnd_q <= 1'b0;
			sc_hit_idx_q  <= '0;
			sc_free_idx_q <= '0;
			tgt_map_q     <= '0;
		end else if (accept) begin
			ks_hit_q      <= 1'b0;
			ks_alt_q      <= 1'b0;
			ks_free_fnd_q <= 1'b0;
			sc_hit_q      <= 1'b0;
			sc_free_fnd_q <= 1'b0;
			tgt_map_q     <= '0;
		end else if (rd_vld_s1 && state_q == pkst_pkg::ST_SCAN) begin
			if (cur_ks_v && ks_rd == ks_key) begin
				ks_hit_q     <= 1'b1;
				ks_hit_idx_q <= rd_idx_s1;
			end
			if (cur_ks_v && ks_rd == (ks_key ^ pkst_pkg::CASE_BIT)) begin
				ks_alt_q <= 1'b1;
			end
			if (cur_sc_v && sc_rd == sc_key) begin
				sc_hit_q     <= 1'b1;
				sc_hit_idx_q <= rd_idx_s1;
			end
			// keysym free slot waits for the recase sweep when there is one
			if (!do_recase && !cur_ks_v && !ks_free_fnd_q) begin
				ks_free_fnd_q <= 1'b1;
				ks_free_idx_q <= rd_idx_s1;
			end
			if (!cur_sc_v && !sc_free_fnd_q) begin
				sc_free_fnd_q <= 1'b1;
				sc_free_idx_q <= rd_idx_s1;
			end
			if (cur_ks_v && tgt_rng) begin
				tgt_map_q[ks_rd[4:0]] <= 1'b1;
			end
		end else if (rd_vld_s1 && state_q == pkst_pkg::ST_RECASE) begin
			// a slot cleared by a case collision counts as free
			if ((!cur_ks_v || recase_clr) && !ks_free_fnd_q) begin
				ks_free_fnd_q <= 1'b1;
				ks_free_idx_q <= rd_idx_s1;
			end
		end
	end

	// per-slot valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_vld_q <= '0;
			sc_vld_q <= '0;
		end else begin
			if (recase_clr) begin
				ks_vld_q[rd_idx_s1] <= 1'b0;
			end
			if (ks_ins) begin
				ks_vld_q[ks_free_idx_q] <= 1'b1;
			end
			if (ks_del) begin
				ks_vld_q[ks_hit_idx_q] <= 1'b0;
			end
			if (sc_ins) begin
				sc_vld_q[sc_free_idx_q] <= 1'b1;
			end
			if (sc_del) begin
				sc_vld_q[sc_hit_idx_q] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (result.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	// ram reads return only while a sweep is running
	a_rd_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == pkst_pkg::ST_SCAN || state_q == pkst_pkg::ST_RECASE))
		else $error("slot read returned outside a sweep");

	// a keysym insert never targets a value already held or an occupied slot
	a_ins_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		ks_ins |-> (!ks_hit_q && !ks_vld_q[ks_free_idx_q]))
		else $error("keysym insert into a held value or an occupied slot");

	// overflow is only reported on a processed event beat
	a_ovf_event: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.overflow) |-> result.data.event_processed)
		else $error("overflow on a beat that is not a processed event");

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != pkst_pkg::ST_IDLE)
		else $error("sequencer stayed idle after an accepted item");
`endif

endmodule

### rtl/pkst_ram.sv
// pkst_ram: simple dual port synchronous ram, one write and one registered read
// no dependencies; contents are undefined until written
module pkst_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
